[hw/rtl/i2cmbe_pkg.sv]
// Shared types and constants for the I2C master bit engine.
package i2cmbe_pkg;

    // Command codes carried on the func field.
    localparam logic [2:0] OP_IDLE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Most significant bit of a data byte.
    localparam int TOP_BIT = 7;

    // Phase indices that mark the end of the bit sections and the ACK phases.
    localparam logic [4:0] PH_WR_BITS_END = 5'd24;
    localparam logic [4:0] PH_WR_ACK_REL  = 5'd25;
    localparam logic [4:0] PH_RD_BITS_END = 5'd16;
    localparam logic [4:0] PH_RD_ACK_SCL  = 5'd17;

    // Sub-phase codes within one written bit.
    localparam logic [1:0] SUB_DATA = 2'd0;
    localparam logic [1:0] SUB_RISE = 2'd1;
    localparam logic [1:0] SUB_FALL = 2'd2;

    // One input beat as held in the input register.
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data_byte;
        logic       rd_ack;
        logic       sda_in;
    } t_beat;

    // One result beat.
    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_seen;
    } t_result;

endpackage

[hw/rtl/i2cmbe_core.sv]
// Phase sequencer: holds the engine state and advances it by one phase per beat.
module i2cmbe_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  i2cmbe_pkg::t_beat   i_beat,
    output i2cmbe_pkg::t_result o_result
);

    logic [2:0] r_op;
    logic [4:0] r_phase;
    logic [1:0] r_sub;
    logic [7:0] r_shift;
    logic       r_ack_mode;
    logic       r_scl;
    logic       r_sda;
    logic       r_ack_flag;
    logic [7:0] r_read_byte;

    logic [2:0] n_op;
    logic [4:0] n_phase;
    logic [1:0] n_sub;
    logic [7:0] n_shift;
    logic       n_ack_mode;
    logic       n_scl;
    logic       n_sda;
    logic       n_ack_flag;
    logic [7:0] n_read_byte;
    logic       n_done;
    logic       last;
    logic       start_cmd;

    // A new command is taken only while idle and only for a known code.
    assign start_cmd = (r_op == i2cmbe_pkg::OP_IDLE) &&
                       ((i_beat.func == i2cmbe_pkg::OP_START) ||
                        (i_beat.func == i2cmbe_pkg::OP_STOP)  ||
                        (i_beat.func == i2cmbe_pkg::OP_WRITE) ||
                        (i_beat.func == i2cmbe_pkg::OP_READ));

    // Work out the state after this beat's phase.
    always_comb begin
        n_op        = r_op;
        n_phase     = r_phase;
        n_sub       = r_sub;
        n_shift     = r_shift;
        n_ack_mode  = r_ack_mode;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_ack_flag  = r_ack_flag;
        n_read_byte = r_read_byte;
        n_done      = 1'b0;
        last        = 1'b0;

        if (start_cmd) begin
            n_op       = i_beat.func;
            n_phase    = 5'd0;
            n_sub      = i2cmbe_pkg::SUB_DATA;
            n_shift    = (i_beat.func == i2cmbe_pkg::OP_WRITE) ? i_beat.data_byte : 8'd0;
            n_ack_mode = i_beat.rd_ack;
        end

        unique case (n_op)
            i2cmbe_pkg::OP_START: begin
                case (n_phase)
                    5'd0:    n_sda = 1'b0;
                    5'd1:    n_scl = 1'b0;
                    5'd2:    n_sda = 1'b1;
                    default: begin
                        n_scl = 1'b1;
                        last  = 1'b1;
                    end
                endcase
            end
            i2cmbe_pkg::OP_STOP: begin
                case (n_phase)
                    5'd0:    n_sda = 1'b1;
                    5'd1:    n_scl = 1'b0;
                    default: begin
                        n_sda = 1'b0;
                        last  = 1'b1;
                    end
                endcase
            end
            i2cmbe_pkg::OP_WRITE: begin
                if (n_phase < i2cmbe_pkg::PH_WR_BITS_END) begin
                    // Three phases per bit: set data, raise SCL, lower SCL.
                    case (n_sub)
                        i2cmbe_pkg::SUB_DATA: begin
                            n_sda   = ~n_shift[i2cmbe_pkg::TOP_BIT];
                            n_shift = {n_shift[6:0], 1'b0};
                            n_sub   = i2cmbe_pkg::SUB_RISE;
                        end
                        i2cmbe_pkg::SUB_RISE: begin
                            n_scl = 1'b0;
                            n_sub = i2cmbe_pkg::SUB_FALL;
                        end
                        default: begin
                            n_scl = 1'b1;
                            n_sub = i2cmbe_pkg::SUB_DATA;
                        end
                    endcase
                end else if (n_phase == i2cmbe_pkg::PH_WR_BITS_END) begin
                    n_sda = 1'b0;
                end else if (n_phase == i2cmbe_pkg::PH_WR_ACK_REL) begin
                    n_scl      = 1'b0;
                    n_ack_flag = ~i_beat.sda_in;
                end else begin
                    n_scl = 1'b1;
                    last  = 1'b1;
                end
            end
            i2cmbe_pkg::OP_READ: begin
                if (n_phase == 5'd0) begin
                    n_sda = 1'b0;
                end
                if (n_phase < i2cmbe_pkg::PH_RD_BITS_END) begin
                    // Even phases raise SCL and sample, odd phases lower it.
                    if (!n_phase[0]) begin
                        n_scl   = 1'b0;
                        n_shift = {n_shift[6:0], i_beat.sda_in};
                    end else begin
                        n_scl = 1'b1;
                    end
                end else if (n_phase == i2cmbe_pkg::PH_RD_BITS_END) begin
                    n_sda = n_ack_mode;
                end else if (n_phase == i2cmbe_pkg::PH_RD_ACK_SCL) begin
                    n_scl = 1'b0;
                end else begin
                    n_scl       = 1'b1;
                    n_sda       = 1'b0;
                    n_read_byte = n_shift;
                    last        = 1'b1;
                end
            end
            default: begin
                last = 1'b0;
            end
        endcase

        // Close the command or move on to the next phase.
        if (n_op != i2cmbe_pkg::OP_IDLE) begin
            if (last) begin
                n_done  = 1'b1;
                n_op    = i2cmbe_pkg::OP_IDLE;
                n_phase = 5'd0;
            end else begin
                n_phase = n_phase + 5'd1;
            end
        end
    end

    // Result as it stands once this beat's phase is done.
    always_comb begin
        o_result.scl_low   = n_scl;
        o_result.sda_low   = n_sda;
        o_result.busy_res  = (n_op != i2cmbe_pkg::OP_IDLE);
        o_result.done_res  = n_done;
        o_result.read_data = n_read_byte;
        o_result.ack_seen  = n_ack_flag;
    end

    // Engine state registers, updated once per stepped beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= i2cmbe_pkg::OP_IDLE;
            r_phase     <= 5'd0;
            r_sub       <= i2cmbe_pkg::SUB_DATA;
            r_shift     <= 8'd0;
            r_ack_mode  <= 1'b0;
            r_scl       <= 1'b0;
            r_sda       <= 1'b0;
            r_ack_flag  <= 1'b0;
            r_read_byte <= 8'd0;
        end else if (i_step) begin
            r_op        <= n_op;
            r_phase     <= n_phase;
            r_sub       <= n_sub;
            r_shift     <= n_shift;
            r_ack_mode  <= n_ack_mode;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_ack_flag  <= n_ack_flag;
            r_read_byte <= n_read_byte;
        end
    end

endmodule

[hw/rtl/i2cmbe_obuf.sv]
// Two-entry result buffer that decouples the engine from a stalling receiver.
module i2cmbe_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  i2cmbe_pkg::t_result i_data,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_stall,
    output i2cmbe_pkg::t_result o_data
);

    i2cmbe_pkg::t_result r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_buf[r_rd_ptr];

    // Storage for buffered result beats.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/i2c_master_bit_engine_unit.sv]
// Top level of the I2C master bit engine: input register, phase sequencer, result buffer.
//
// Each input beat is one phase tick from a prescaler, carrying a command code,
// a byte to write, the ACK choice for a read and the sampled SDA level. A
// command starts only while the engine is idle; start takes 4 ticks, stop 3,
// a byte write with ACK sampling 27 and a byte read with ACK or NACK 19.
// Every input beat gives exactly one result beat: the SCL and SDA pull-low
// drives, busy and done flags, the last read byte and the last received ACK.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// A beat is held in the input register, then one phase of the sequencer is
// applied and its result enters a two-entry buffer. The result is offered
// once it has been stored in the buffer; one beat moves per cycle while the
// receiver keeps up.
// When the receiver stalls, the buffer fills and o_stall rises once both
// entries and the input register hold beats; no beat is lost or repeated.
// After reset the engine is idle with both lines released and all flags,
// the read byte and the ACK flag cleared.
module i2c_master_bit_engine_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_rd_ack,
    input  logic       i_sda_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_scl_low,
    output logic       o_sda_low,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_read_data,
    output logic       o_ack_seen
);

    i2cmbe_pkg::t_beat   r_beat;
    logic                r_in_valid;
    logic                buf_ready;
    logic                advance;
    logic                accept;
    i2cmbe_pkg::t_result step_result;
    i2cmbe_pkg::t_result out_result;

    assign advance = r_in_valid && buf_ready;
    assign o_stall = r_in_valid && !buf_ready;
    assign accept  = i_valid && !o_stall;

    // Input register: loads a beat whenever it is empty or the previous one moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat.func      <= i_func;
            r_beat.data_byte <= i_data_byte;
            r_beat.rd_ack    <= i_rd_ack;
            r_beat.sda_in    <= i_sda_in;
        end
    end

    // Phase sequencer.
    i2cmbe_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_beat   (r_beat),
        .o_result (step_result)
    );

    // Result buffer towards the receiver.
    i2cmbe_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_data  (step_result),
        .o_ready (buf_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_result)
    );

    assign o_scl_low   = out_result.scl_low;
    assign o_sda_low   = out_result.sda_low;
    assign o_busy_res  = out_result.busy_res;
    assign o_done_res  = out_result.done_res;
    assign o_read_data = out_result.read_data;
    assign o_ack_seen  = out_result.ack_seen;

endmodule

[tb/tb_i2c_master_bit_engine_unit.sv]
// Self-checking testbench for the I2C master bit engine: tick stimulus, line-state prediction.
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine_unit;

    // How the sampled SDA level is chosen for the ticks of one command.
    typedef enum {SDA_LOW, SDA_HIGH, SDA_RAND} t_sda_mode;

    // Tick counts of each command.
    localparam int START_TICKS = 4;
    localparam int STOP_TICKS  = 3;
    localparam int WRITE_TICKS = 27;
    localparam int READ_TICKS  = 19;

    // Rough number of input beats in each idling phase of the random part.
    localparam int TICKS_PER_PHASE = 325;

    // Tracks the engine state per accepted tick and holds the line states still due.
    class line_state_tracker;
        logic [2:0]          op;
        logic [4:0]          phase;
        logic [7:0]          shreg;
        logic                ack_mode;
        logic                scl_drv;
        logic                sda_drv;
        logic                ack_flag;
        logic [7:0]          rd_byte;
        i2cmbe_pkg::t_result line_states_due[$];
        int                  fails;

        function new();
            op       = i2cmbe_pkg::OP_IDLE;
            phase    = '0;
            shreg    = '0;
            ack_mode = 1'b0;
            scl_drv  = 1'b0;
            sda_drv  = 1'b0;
            ack_flag = 1'b0;
            rd_byte  = '0;
            fails    = 0;
        endfunction

        // Applies the current phase of the running command; returns 1 on its last phase.
        function bit apply_phase(logic sda_in);
            logic [1:0] sub;
            case (op)
                i2cmbe_pkg::OP_START: begin
                    case (phase)
                        5'd0: sda_drv = 1'b0;
                        5'd1: scl_drv = 1'b0;
                        5'd2: sda_drv = 1'b1;
                        default: begin
                            scl_drv = 1'b1;
                            return 1'b1;
                        end
                    endcase
                    return 1'b0;
                end
                i2cmbe_pkg::OP_STOP: begin
                    case (phase)
                        5'd0: sda_drv = 1'b1;
                        5'd1: scl_drv = 1'b0;
                        default: begin
                            sda_drv = 1'b0;
                            return 1'b1;
                        end
                    endcase
                    return 1'b0;
                end
                i2cmbe_pkg::OP_WRITE: begin
                    if (phase < i2cmbe_pkg::PH_WR_BITS_END) begin
                        sub = 2'(phase % 3);
                        if (sub == i2cmbe_pkg::SUB_DATA) begin
                            sda_drv = ~shreg[i2cmbe_pkg::TOP_BIT];
                            shreg   = {shreg[6:0], 1'b0};
                        end else if (sub == i2cmbe_pkg::SUB_RISE) begin
                            scl_drv = 1'b0;
                        end else begin
                            scl_drv = 1'b1;
                        end
                        return 1'b0;
                    end
                    if (phase == i2cmbe_pkg::PH_WR_BITS_END) begin
                        sda_drv = 1'b0;
                        return 1'b0;
                    end
                    if (phase == i2cmbe_pkg::PH_WR_ACK_REL) begin
                        scl_drv  = 1'b0;
                        ack_flag = ~sda_in;
                        return 1'b0;
                    end
                    scl_drv = 1'b1;
                    return 1'b1;
                end
                i2cmbe_pkg::OP_READ: begin
                    if (phase == 5'd0) sda_drv = 1'b0;
                    if (phase < i2cmbe_pkg::PH_RD_BITS_END) begin
                        if (!phase[0]) begin
                            scl_drv = 1'b0;
                            shreg   = {shreg[6:0], sda_in};
                        end else begin
                            scl_drv = 1'b1;
                        end
                        return 1'b0;
                    end
                    if (phase == i2cmbe_pkg::PH_RD_BITS_END) begin
                        sda_drv = ack_mode;
                        return 1'b0;
                    end
                    if (phase == i2cmbe_pkg::PH_RD_ACK_SCL) begin
                        scl_drv = 1'b0;
                        return 1'b0;
                    end
                    scl_drv = 1'b1;
                    sda_drv = 1'b0;
                    rd_byte = shreg;
                    return 1'b1;
                end
                default: return 1'b1;
            endcase
        endfunction

        // Notes an accepted input beat and queues the line state it leads to.
        function void take_tick(i2cmbe_pkg::t_beat b);
            i2cmbe_pkg::t_result r;
            logic                done;
            done = 1'b0;
            if (op == i2cmbe_pkg::OP_IDLE && b.func >= i2cmbe_pkg::OP_START &&
                b.func <= i2cmbe_pkg::OP_READ) begin
                op       = b.func;
                phase    = '0;
                shreg    = (b.func == i2cmbe_pkg::OP_WRITE) ? b.data_byte : 8'd0;
                ack_mode = b.rd_ack;
            end
            if (op != i2cmbe_pkg::OP_IDLE) begin
                if (apply_phase(b.sda_in)) begin
                    done  = 1'b1;
                    op    = i2cmbe_pkg::OP_IDLE;
                    phase = '0;
                end else begin
                    phase = phase + 5'd1;
                end
            end
            r.scl_low   = scl_drv;
            r.sda_low   = sda_drv;
            r.busy_res  = (op != i2cmbe_pkg::OP_IDLE);
            r.done_res  = done;
            r.read_data = rd_byte;
            r.ack_seen  = ack_flag;
            line_states_due.push_back(r);
        endfunction

        // Compares an accepted result beat with the oldest line state due.
        function void match_result(i2cmbe_pkg::t_result got);
            i2cmbe_pkg::t_result want;
            if (line_states_due.size() == 0) begin
                $error("result beat arrived with nothing due");
                fails++;
                return;
            end
            want = line_states_due.pop_front();
            if (got.scl_low !== want.scl_low) begin
                $error("scl_low: expected %0d, actual %0d", want.scl_low, got.scl_low);
                fails++;
            end
            if (got.sda_low !== want.sda_low) begin
                $error("sda_low: expected %0d, actual %0d", want.sda_low, got.sda_low);
                fails++;
            end
            if (got.busy_res !== want.busy_res) begin
                $error("busy_res: expected %0d, actual %0d", want.busy_res, got.busy_res);
                fails++;
            end
            if (got.done_res !== want.done_res) begin
                $error("done_res: expected %0d, actual %0d", want.done_res, got.done_res);
                fails++;
            end
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected 0x%02h, actual 0x%02h",
                       want.read_data, got.read_data);
                fails++;
            end
            if (got.ack_seen !== want.ack_seen) begin
                $error("ack_seen: expected %0d, actual %0d", want.ack_seen, got.ack_seen);
                fails++;
            end
        endfunction

        function int pending();
            return line_states_due.size();
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [2:0] i_func      = i2cmbe_pkg::OP_IDLE;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_rd_ack    = 1'b0;
    logic       i_sda_in    = 1'b0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_scl_low;
    logic       o_sda_low;
    logic       o_busy_res;
    logic       o_done_res;
    logic [7:0] o_read_data;
    logic       o_ack_seen;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int ticks_sent     = 0;

    line_state_tracker tracker = new();

    i2c_master_bit_engine_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .i_rd_ack    (i_rd_ack),
        .i_sda_in    (i_sda_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_scl_low   (o_scl_low),
        .o_sda_low   (o_sda_low),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_read_data (o_read_data),
        .o_ack_seen  (o_ack_seen)
    );

    // Clock generation.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Watches both channels: input beats feed the tracker before result beats are matched.
    always @(posedge i_clk) begin
        i2cmbe_pkg::t_beat   b;
        i2cmbe_pkg::t_result got;
        if (i_rst_n && i_valid && !o_stall) begin
            b.func      = i_func;
            b.data_byte = i_data_byte;
            b.rd_ack    = i_rd_ack;
            b.sda_in    = i_sda_in;
            tracker.take_tick(b);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got.scl_low   = o_scl_low;
            got.sda_low   = o_sda_low;
            got.busy_res  = o_busy_res;
            got.done_res  = o_done_res;
            got.read_data = o_read_data;
            got.ack_seen  = o_ack_seen;
            tracker.match_result(got);
        end
        i_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Offers one tick beat, with random idle cycles ahead of it, and waits for acceptance.
    task automatic drive_tick(input logic [2:0] f, input logic [7:0] d, input logic a,
                              input logic s);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= f;
        i_data_byte <= d;
        i_rd_ack    <= a;
        i_sda_in    <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        ticks_sent++;
    endtask

    function automatic logic pick_sda(t_sda_mode mode);
        case (mode)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom_range(1));
        endcase
    endfunction

    // A tick carrying a code that starts nothing.
    task automatic idle_tick(input t_sda_mode mode);
        logic [2:0] f;
        do begin
            f = 3'($urandom_range(7));
        end while (f >= i2cmbe_pkg::OP_START && f <= i2cmbe_pkg::OP_READ);
        drive_tick(f, 8'($urandom_range(255)), 1'($urandom_range(1)), pick_sda(mode));
    endtask

    // Issues a command on its first tick and fills the rest with random ignored fields.
    task automatic run_command(input logic [2:0] op, input logic [7:0] d, input logic a,
                               input t_sda_mode mode);
        int n;
        case (op)
            i2cmbe_pkg::OP_START: n = START_TICKS;
            i2cmbe_pkg::OP_STOP:  n = STOP_TICKS;
            i2cmbe_pkg::OP_WRITE: n = WRITE_TICKS;
            default:              n = READ_TICKS;
        endcase
        drive_tick(op, d, a, pick_sda(mode));
        for (int i = 1; i < n; i++) begin
            drive_tick(3'($urandom_range(7)), 8'($urandom_range(255)),
                       1'($urandom_range(1)), pick_sda(mode));
        end
    endtask

    // A well-formed transfer: start, one to three byte writes or reads, each at times after an idle tick, stop.
    task automatic run_transfer();
        int n;
        n = $urandom_range(1, 3);
        run_command(i2cmbe_pkg::OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
                    SDA_RAND);
        repeat (n) begin
            if ($urandom_range(3) == 0) idle_tick(SDA_RAND);
            if ($urandom_range(1) == 0) begin
                run_command(i2cmbe_pkg::OP_WRITE, 8'($urandom_range(255)),
                            1'($urandom_range(1)), SDA_RAND);
            end else begin
                run_command(i2cmbe_pkg::OP_READ, 8'($urandom_range(255)),
                            1'($urandom_range(1)), SDA_RAND);
            end
        end
        run_command(i2cmbe_pkg::OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                    SDA_RAND);
    endtask

    // Main stimulus sequence.
    initial begin
        logic [2:0] f;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: codes that start nothing, stop from idle, then a full transfer
        // with extreme bytes, ACK and NACK in both directions, all back to back.
        idle_tick(SDA_LOW);
        idle_tick(SDA_HIGH);
        run_command(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, SDA_HIGH);
        run_command(i2cmbe_pkg::OP_START, 8'hFF, 1'b1, SDA_LOW);
        run_command(i2cmbe_pkg::OP_WRITE, 8'h00, 1'b0, SDA_LOW);
        run_command(i2cmbe_pkg::OP_WRITE, 8'hFF, 1'b1, SDA_HIGH);
        run_command(i2cmbe_pkg::OP_WRITE, 8'hA5, 1'b0, SDA_RAND);
        run_command(i2cmbe_pkg::OP_READ, 8'h00, 1'b1, SDA_HIGH);
        run_command(i2cmbe_pkg::OP_READ, 8'hFF, 1'b0, SDA_LOW);
        run_command(i2cmbe_pkg::OP_READ, 8'h3C, 1'b1, SDA_RAND);
        idle_tick(SDA_RAND);
        run_command(i2cmbe_pkg::OP_STOP, 8'hFF, 1'b1, SDA_LOW);

        // Random part over four idling phases.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            while (ticks_sent < (ph + 1) * TICKS_PER_PHASE) begin
                if ($urandom_range(99) < 80) begin
                    run_transfer();
                end else begin
                    // Noise: a lone command of any kind or a code that starts nothing.
                    f = 3'($urandom_range(7));
                    if (f >= i2cmbe_pkg::OP_START && f <= i2cmbe_pkg::OP_READ) begin
                        run_command(f, 8'($urandom_range(255)), 1'($urandom_range(1)),
                                    SDA_RAND);
                    end else begin
                        idle_tick(SDA_RAND);
                    end
                end
            end
        end

        // Drain the result channel, then keep watching for stray beats before the verdict.
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
